/* rtl/skt_pkg.sv */
// Package for the sorted key table: sizes, command and status codes, beat types.
`default_nettype none
package skt_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 32;
    localparam int ENTRY_COUNT_W = 7;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [PAY_W-1:0]         found_payload;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_beat_t;

    typedef struct packed {
        logic load_flags;
        logic shift_ins;
        logic shift_del;
    } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/skt_cell.sv */
// One table slot: holds a key and payload, compares against the command key, shifts with neighbors.
`default_nettype none
module skt_cell
    import skt_pkg::*;
(
    input  wire logic                     clk,
    input  wire cell_ctl_t                ctl,
    input  wire logic                     occupied,
    input  wire logic signed [KEY_W-1:0]  cmp_key,
    input  wire logic signed [KEY_W-1:0]  new_key,
    input  wire logic [PAY_W-1:0]         new_payload,
    input  wire logic signed [KEY_W-1:0]  left_key,
    input  wire logic [PAY_W-1:0]         left_payload,
    input  wire logic                     left_gt,
    input  wire logic signed [KEY_W-1:0]  right_key,
    input  wire logic [PAY_W-1:0]         right_payload,
    output logic signed [KEY_W-1:0]       key,
    output logic [PAY_W-1:0]              payload,
    output logic                          gt,
    output logic                          eq
);

    logic signed [KEY_W-1:0] key_reg;
    logic [PAY_W-1:0]        payload_reg;
    logic                    gt_reg;
    logic                    eq_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_flags)
        begin
            gt_reg <= !occupied || (key_reg > cmp_key);
            eq_reg <= occupied && (key_reg == cmp_key);
        end
        if (ctl.shift_ins && gt_reg)
        begin
            key_reg     <= left_gt ? left_key : new_key;
            payload_reg <= left_gt ? left_payload : new_payload;
        end
        else if (ctl.shift_del && (gt_reg || eq_reg))
        begin
            key_reg     <= right_key;
            payload_reg <= right_payload;
        end
    end

    assign key     = key_reg;
    assign payload = payload_reg;
    assign gt      = gt_reg;
    assign eq      = eq_reg;

endmodule
`default_nettype wire

/* rtl/sorted_key_table_unit.sv */
// Sorted key table top level: command/response handshake, control, and the row of cells.
//
// Usage: send one command beat (insert, delete or lookup with key and payload)
// on cmd; one response beat (status, found payload, entry count) follows on rsp.
// cmd_ready is high while no command is in flight; it may take the next
// command while the previous response still waits to be taken.
// Sequence: the accepting edge loads the compare flags in every cell, then
// the edge that ends the EXEC state applies the shift in all cells at once
// and registers the response.
// A new command is not taken until the compare-then-shift pass of the cell
// row for the previous one is done.
// If rsp_ready is low with a response pending, the next command waits in its
// second step, leaving the table untouched, until the response is taken.
// Reset empties the table (entry count zero) and drops any pending response.
// Capacity is 64 entries; an insert of a new key into a full table reports table full.
`default_nettype none
module sorted_key_table_unit
    import skt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_beat_t cmd,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_beat_t      rsp
);

    typedef enum logic {IDLE, EXEC} state_t;

    state_t           state_reg;
    cmd_beat_t        cmd_reg;
    logic [CNT_W-1:0] count_reg;
    rsp_beat_t        rsp_reg;
    logic             rsp_valid_reg;

    cell_ctl_t               ctl;
    logic                    fire;
    logic                    any_eq;
    logic                    full;
    logic [PAY_W-1:0]        hit_payload;
    logic                    do_ins;
    logic                    do_del;
    logic [1:0]              status;
    logic [PAY_W-1:0]        found;
    logic [CNT_W-1:0]        count_next;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [PAY_W-1:0]        cell_pay [CAPACITY];
    logic [CAPACITY-1:0]     cell_gt;
    logic [CAPACITY-1:0]     cell_eq;
    logic [CAPACITY-1:0]     occupied;

    assign cmd_ready = (state_reg == IDLE);
    assign fire      = (state_reg == EXEC) && (!rsp_valid_reg || rsp_ready);
    assign any_eq    = |cell_eq;
    assign full      = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        hit_payload = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            hit_payload = hit_payload | (cell_eq[i] ? cell_pay[i] : '0);
        end
    end

    always_comb
    begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        status     = ST_DONE;
        found      = '0;
        count_next = count_reg;
        case (cmd_reg.command)
            CMD_INSERT:
            begin
                if (any_eq)
                begin
                    status = ST_DUPLICATE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_DELETE:
            begin
                if (any_eq)
                begin
                    do_del     = 1'b1;
                    found      = hit_payload;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            CMD_LOOKUP:
            begin
                if (any_eq)
                begin
                    found = hit_payload;
                end
                else
                begin
                    status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status = ST_DONE;
            end
        endcase
    end

    assign ctl.load_flags = cmd_valid && cmd_ready;
    assign ctl.shift_ins  = fire && do_ins;
    assign ctl.shift_del  = fire && do_del;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [KEY_W-1:0] l_key;
            logic [PAY_W-1:0]        l_pay;
            logic                    l_gt;
            logic signed [KEY_W-1:0] r_key;
            logic [PAY_W-1:0]        r_pay;

            assign occupied[g] = (CNT_W'(g) < count_reg);

            if (g == 0)
            begin : g_first
                assign l_key = cell_key[g];
                assign l_pay = cell_pay[g];
                assign l_gt  = 1'b0;
            end
            else
            begin : g_mid_l
                assign l_key = cell_key[g-1];
                assign l_pay = cell_pay[g-1];
                assign l_gt  = cell_gt[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign r_key = cell_key[g];
                assign r_pay = cell_pay[g];
            end
            else
            begin : g_mid_r
                assign r_key = cell_key[g+1];
                assign r_pay = cell_pay[g+1];
            end

            skt_cell u_cell (
                .clk           (clk),
                .ctl           (ctl),
                .occupied      (occupied[g]),
                .cmp_key       (cmd.key),
                .new_key       (cmd_reg.key),
                .new_payload   (cmd_reg.payload),
                .left_key      (l_key),
                .left_payload  (l_pay),
                .left_gt       (l_gt),
                .right_key     (r_key),
                .right_payload (r_pay),
                .key           (cell_key[g]),
                .payload       (cell_pay[g]),
                .gt            (cell_gt[g]),
                .eq            (cell_eq[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                IDLE:
                begin
                    if (cmd_valid)
                    begin
                        state_reg <= EXEC;
                    end
                end
                EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase

            if (fire)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            rsp_reg.status        <= status;
            rsp_reg.found_payload <= found;
            rsp_reg.entry_count   <= ENTRY_COUNT_W'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
